@@ src/ipv4_lpm_pkg.sv @@
// Shared types and codes for the IPv4 longest-prefix route lookup block.
// Holds the request and result payload structs and the operation codes.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package ipv4_lpm_pkg;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam int REG_ENTRY_COUNT = 0;

	typedef struct packed {
		logic        op;
		logic [9:0]  entry_index;
		logic [31:0] route_prefix;
		logic [31:0] route_mask;
		logic [31:0] route_next_hop;
		logic [3:0]  route_port;
		logic [31:0] dest_addr;
	} lpm_req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] gateway;
		logic [3:0]  out_port;
		logic [31:0] matched_mask;
	} lpm_result_t;

endpackage

`default_nettype wire

@@ src/ipv4_lpm_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Used for the route table; no package dependencies.
`default_nettype none

module ipv4_lpm_ram #(
	parameter int WIDTH = 100,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ src/ipv4_longest_prefix_route_lookup.sv @@
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+---------------------------------
// request   | start in, busy out            | req   (ipv4_lpm_pkg::lpm_req_t)
// result    | done out, one-cycle strobe    | result (ipv4_lpm_pkg::lpm_result_t)
// config    | APB psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A write request stores one route entry in the cycle it is taken and leaves busy low.
// A lookup request scans the table RAM one entry per cycle, over the first
// min(entry_count, TABLE_ENTRIES) entries, and then pulses done with the result.
// Busy stays high until the result cycle.
// Reset clears the control state and entry_count; the table needs no clearing.
// The receiver cannot stall: the result is valid for the one cycle that done is high.
// Depends on ipv4_lpm_pkg and ipv4_lpm_ram.
`default_nettype none

module ipv4_longest_prefix_route_lookup #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int PORT_BITS     = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire ipv4_lpm_pkg::lpm_req_t    req,
	output logic                          done,
	output ipv4_lpm_pkg::lpm_result_t      result,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [2:0]               paddr,
	input  wire logic [31:0]              pwdata,
	output logic      [31:0]              prdata,
	output logic                          pready
);

	import ipv4_lpm_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int EW = 96 + PORT_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]            state_q;
	logic [10:0]           entry_count_q;
	logic [CW-1:0]         addr_q;
	logic [CW-1:0]         limit_q;
	logic [31:0]           dest_q;
	logic                  rd_vld_s1;
	logic                  hit_q;
	logic [31:0]           best_mask_q;
	logic [31:0]           best_hop_q;
	logic [PORT_BITS-1:0]  best_port_q;
	logic                  done_q;
	lpm_result_t           result_q;

	logic                  accept;
	logic                  wr_entry;
	logic                  issue;
	logic                  cfg_wr;
	logic [CW-1:0]         limit_next;
	logic [AW-1:0]         ram_addr;
	logic [EW-1:0]         ram_wdata;
	logic [EW-1:0]         ram_rdata;
	logic [PORT_BITS+3:0]  port_wide;
	logic [PORT_BITS+3:0]  best_port_wide;
	logic [31:0]           rd_prefix;
	logic [31:0]           rd_mask;
	logic [31:0]           rd_hop;
	logic [PORT_BITS-1:0]  rd_port;
	logic                  rd_match;
	logic                  rd_take;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_entry = accept && (req.op == OP_WRITE)
		&& (32'(req.entry_index) < 32'(TABLE_ENTRIES));
	assign issue  = (state_q == ST_SCAN) && (addr_q < limit_q);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {21'd0, entry_count_q} : 32'd0;

	// An entry_count above the table size searches the whole table.
	assign limit_next = (32'(entry_count_q) > 32'(TABLE_ENTRIES))
		? CW'(TABLE_ENTRIES) : CW'(entry_count_q);

	// Writes only happen while idle, so the single port is never contended.
	assign ram_addr  = wr_entry ? AW'(req.entry_index) : addr_q[AW-1:0];
	assign port_wide = {{PORT_BITS{1'b0}}, req.route_port};
	assign ram_wdata = {req.route_prefix, req.route_mask, req.route_next_hop,
		port_wide[PORT_BITS-1:0]};

	ipv4_lpm_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (wr_entry),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign rd_prefix = ram_rdata[EW-1 -: 32];
	assign rd_mask   = ram_rdata[EW-33 -: 32];
	assign rd_hop    = ram_rdata[EW-65 -: 32];
	assign rd_port   = ram_rdata[PORT_BITS-1:0];

	// Strictly larger masks replace the best entry, so the lowest index wins ties.
	assign rd_match = ((rd_prefix ^ dest_q) & rd_mask) == 32'd0;
	assign rd_take  = rd_vld_s1 && rd_match && (!hit_q || (rd_mask > best_mask_q));

	assign best_port_wide = {4'd0, best_port_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			addr_q        <= '0;
			limit_q       <= '0;
			rd_vld_s1     <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q    <= (state_q == ST_FLUSH);
			rd_vld_s1 <= issue;
			if (cfg_wr && (32'(paddr[2]) == 32'(REG_ENTRY_COUNT))) begin
				entry_count_q <= pwdata[10:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.op == OP_LOOKUP)) begin
						state_q <= ST_SCAN;
						addr_q  <= '0;
						limit_q <= limit_next;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + CW'(1);
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.op == OP_LOOKUP)) begin
			dest_q      <= req.dest_addr;
			hit_q       <= 1'b0;
			best_mask_q <= '0;
			best_hop_q  <= '0;
			best_port_q <= '0;
		end else if (rd_take) begin
			hit_q       <= 1'b1;
			best_mask_q <= rd_mask;
			best_hop_q  <= rd_hop;
			best_port_q <= rd_port;
		end
		if (state_q == ST_FLUSH) begin
			result_q.found        <= hit_q;
			result_q.gateway      <= best_hop_q;
			result_q.out_port     <= best_port_wide[3:0];
			result_q.matched_mask <= best_mask_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ src/ipv4_lpm_chk.sv @@
// Port-level checker for the IPv4 longest-prefix route lookup block.
// Depends on ipv4_lpm_pkg; bound to the top level at the end of this file.
`default_nettype none

module ipv4_lpm_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire ipv4_lpm_pkg::lpm_req_t     req,
	input wire logic                      done,
	input wire ipv4_lpm_pkg::lpm_result_t  result
);

	import ipv4_lpm_pkg::*;

	// A lookup request always raises busy in the cycle after it is taken.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.op == OP_LOOKUP) |=> busy)
		else $error("lookup request did not raise busy");

	// A route write completes at once and produces no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.op == OP_WRITE) |=> !busy && !done)
		else $error("route write raised busy or produced a result");

	// The block is free again in the cycle its result is shown.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// Two results never come back to back.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in consecutive cycles");

	// A miss reports zeros in every payload field.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |->
			(result.gateway == 32'd0) && (result.out_port == 4'd0)
			&& (result.matched_mask == 32'd0))
		else $error("miss result carries nonzero fields");

endmodule

bind ipv4_longest_prefix_route_lookup ipv4_lpm_chk u_lpm_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.result(result)
);

`default_nettype wire
